@@ hw/rtl/bgf_pkg.sv @@
// Shared types, constants and build-time weight table functions for the
// gray bilateral filter. No dependencies.
package bgf_pkg;

  localparam int unsigned RADIUS_DEF      = 2;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned MAX_HEIGHT      = 4096;

  localparam int unsigned ROW_W        = 13;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

  localparam int unsigned SROM_LEN = 128;
  localparam int unsigned RROM_LEN = 256;
  typedef logic [SROM_LEN-1:0][31:0] spatial_rom_t;
  typedef logic [RROM_LEN-1:0][31:0] range_rom_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CENTER = 6'b000010,
    ST_TAPS   = 6'b000100,
    ST_FLUSH  = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } bgf_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } bgf_div_ctl_t;

  localparam logic [63:0] ONE_Q31  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] HALF_Q31 = 64'h0000_0000_4000_0000;

  // Shift-subtract division, used only while building the tables.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q31_mul(input logic [63:0] x, input logic [63:0] y);
    return (x * y + HALF_Q31) >> 31;
  endfunction

  // e^(-1/b) in Q1.31 by the alternating series.
  function automatic logic [63:0] exp_base(input logic [63:0] b);
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    t   = ONE_Q31;
    pos = ONE_Q31;
    neg = '0;
    for (int k = 1; k < 64; k++) begin
      if (t != 0) begin
        t = div_u64(t, b * 64'(k));
        if (k % 2 == 1) neg = neg + t;
        else pos = pos + t;
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [31:0] pow_entry(input logic [63:0] base, input logic [31:0] a,
                                            input int unsigned wb);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] vmax;
    p    = base;
    r    = ONE_Q31;
    vmax = (64'd1 << wb) - 64'd1;
    for (int i = 0; i < 32; i++) begin
      if (a[i]) r = q31_mul(r, p);
      p = q31_mul(p, p);
    end
    v = ((r << wb) + HALF_Q31) >> 31;
    if (v > vmax) v = vmax;
    return v[31:0];
  endfunction

  function automatic spatial_rom_t build_spatial(input int unsigned radius, input int unsigned wb);
    spatial_rom_t rom;
    logic [63:0]  base;
    base = exp_base(64'(2 * radius * radius));
    for (int i = 0; i < SROM_LEN; i++) begin
      if (i <= 2 * radius * radius) rom[i] = pow_entry(base, 32'(i), wb);
      else rom[i] = '0;
    end
    return rom;
  endfunction

  function automatic range_rom_t build_range(input int unsigned radius, input int unsigned wb);
    range_rom_t  rom;
    logic [63:0] base;
    base = exp_base(64'(8 * radius * radius));
    for (int i = 0; i < RROM_LEN; i++) begin
      rom[i] = pow_entry(base, 32'(i * i), wb);
    end
    return rom;
  endfunction

endpackage

@@ hw/rtl/bgf_line_mem.sv @@
// Line store of the bilateral filter: one write port, one registered read port.
// Depends on nothing.
module bgf_line_mem #(
  parameter int unsigned DEPTH  = 6144,
  parameter int unsigned ADDR_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bgf_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the weighted mean.
// Depends on bgf_pkg for the control struct.
module bgf_divider #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 29,
  parameter int unsigned Q_W   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bgf_pkg::bgf_div_ctl_t ctl_i,
  output bgf_pkg::bgf_div_ctl_t ctl_o,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [Q_W-1:0]        quot_o
);
  import bgf_pkg::*;

  localparam int unsigned CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dsh_q, dsh_d;
  logic [Q_W-1:0]   quot_q, quot_d;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(Q_W - 1);
      rem_d  = num_i;
      dsh_d  = NUM_W'(den_i) << (Q_W - 1);
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d         = rem_q - dsh_q;
        quot_d[cnt_q] = 1'b1;
      end
      dsh_d = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign ctl_o.start = busy_q;
  assign ctl_o.done  = done_q;
  assign quot_o      = quot_q;

endmodule

@@ hw/rtl/gray_bilateral_filter_unit.sv @@
// Gray bilateral filter top level: line store, tap sequencer, weights, divider (bgf_pkg,
// bgf_line_mem, bgf_divider). One request at a time; a request with no result returns to idle
// after the centre read. With a result: one window tap a cycle, a flush of the weight pipeline,
// the divider run and the output load; output stalls hold the block busy.
// Reset: asynchronous, active low; counters clear, registers load 640 x 480, no line clearing.
module gray_bilateral_filter_unit #(
  parameter int unsigned RADIUS      = bgf_pkg::RADIUS_DEF,
  parameter int unsigned MAX_WIDTH   = bgf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WEIGHT_BITS = bgf_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [bgf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                     s_axis_tuser,   // [0] kind (1 = drain tick)
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] filtered
  output logic [0:0]                     m_axis_tuser    // [0] frame_end
);
  import bgf_pkg::*;

  localparam int unsigned SLOTS   = 2 * RADIUS + 2;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WEFF_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned TAP_N   = 2 * RADIUS + 1;
  localparam int unsigned OFF_W   = $clog2(TAP_N);
  localparam int unsigned K_W     = ROW_W + WEFF_W;
  localparam int unsigned ADDR_W  = SLOT_W + COL_W;
  localparam int unsigned DEPTH   = SLOTS << COL_W;
  localparam int unsigned D2_W    = $clog2(SROM_LEN);
  localparam int unsigned PROD_W  = 2 * WEIGHT_BITS;
  localparam int unsigned WSUM_W  = WEIGHT_BITS + $clog2(TAP_N * TAP_N + 1);
  localparam int unsigned PSUM_W  = WSUM_W + 8;

  localparam spatial_rom_t SROM = build_spatial(RADIUS, WEIGHT_BITS);
  localparam range_rom_t   RROM = build_range(RADIUS, WEIGHT_BITS);

  // configuration registers and effective frame size
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WEFF_W-1:0]       w_eff;
  logic [ROW_W-1:0]        h_eff;
  logic [K_W-1:0]          delay;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (13'(width_q) > 13'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_q);
    end
  end

  // first output is due once RADIUS rows and RADIUS pixels lie ahead of it
  assign delay = K_W'(RADIUS) * K_W'(w_eff) + K_W'(RADIUS);

  // input and output position counters
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [SLOT_W-1:0] in_slot_q, out_slot_q;
  logic [K_W-1:0]    k_q;

  bgf_state_e state_q, state_d;

  logic       accept, store, done_frame, emit_now, emit_q;
  logic       in_col_wrap, out_col_wrap, out_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign done_frame    = (in_row_q >= h_eff);
  assign store         = accept && !done_frame && !s_axis_tuser[0];
  // a pixel after the frame's last pixel counts as a drain tick
  assign emit_now      = done_frame || (store && (k_q >= delay));
  assign in_col_wrap   = ((WEFF_W + 1)'(in_col_q) + 1'b1) >= (WEFF_W + 1)'(w_eff);
  assign out_col_wrap  = ((WEFF_W + 1)'(out_col_q) + 1'b1) >= (WEFF_W + 1)'(w_eff);
  assign out_last      = ((ROW_W + 1)'(out_row_q) + 1'b1) >= (ROW_W + 1)'(h_eff) && out_col_wrap;

  // window walk
  logic [OFF_W-1:0]    dy_q, dx_q;
  logic [SLOT_W-1:0]   tap_slot_q;
  logic [SLOT_W:0]     start_slot;
  logic signed [ROW_W:0] tap_y;
  logic signed [COL_W+1:0] tap_x;
  logic                tap_in;
  logic [OFF_W-1:0]    ady, adx;
  logic [D2_W-1:0]     d2;
  logic                last_dx, last_dy;

  assign start_slot = (SLOT_W + 1)'(out_slot_q) + (SLOT_W + 1)'(SLOTS - RADIUS);
  assign tap_y  = (ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(dy_q) - (ROW_W + 1)'(RADIUS);
  assign tap_x  = (COL_W + 2)'(out_col_q) + (COL_W + 2)'(dx_q) - (COL_W + 2)'(RADIUS);
  assign tap_in = !tap_y[ROW_W] && (tap_y[ROW_W-1:0] < h_eff) &&
                  !tap_x[COL_W+1] && (tap_x[COL_W:0] < (COL_W + 1)'(w_eff));
  assign ady    = (dy_q >= OFF_W'(RADIUS)) ? dy_q - OFF_W'(RADIUS) : OFF_W'(RADIUS) - dy_q;
  assign adx    = (dx_q >= OFF_W'(RADIUS)) ? dx_q - OFF_W'(RADIUS) : OFF_W'(RADIUS) - dx_q;
  assign d2     = D2_W'(8'(ady) * 8'(ady) + 8'(adx) * 8'(adx));
  assign last_dx = (dx_q == OFF_W'(TAP_N - 1));
  assign last_dy = (dy_q == OFF_W'(TAP_N - 1));

  // line store
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  always_comb begin
    if (state_q == ST_CENTER) begin
      raddr = {out_slot_q, out_col_q};
    end else begin
      raddr = {tap_slot_q, tap_x[COL_W-1:0]};
    end
  end

  bgf_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i ({in_slot_q, in_col_q}),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // weight pipeline: read, product of weights, accumulate
  logic                  s1_ctr_q, s1_vld_q, s2_vld_q;
  logic [D2_W-1:0]       s1_d2_q;
  logic [7:0]            center_q, p2_q, diff;
  logic [PROD_W-1:0]     prod_q;
  logic [WEIGHT_BITS-1:0] wt;
  logic [PSUM_W-1:0]     psum_q;
  logic [WSUM_W-1:0]     wsum_q;

  assign diff = (rdata > center_q) ? rdata - center_q : center_q - rdata;
  assign wt   = prod_q[PROD_W-1:WEIGHT_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctr_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_ctr_q <= (state_q == ST_CENTER) && emit_q;
      s1_vld_q <= (state_q == ST_TAPS) && tap_in;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_d2_q <= d2;
    if (s1_ctr_q) begin
      center_q <= rdata;
    end
    prod_q <= PROD_W'(SROM[s1_d2_q][WEIGHT_BITS-1:0]) * PROD_W'(RROM[diff][WEIGHT_BITS-1:0]);
    p2_q   <= rdata;
    if (state_q == ST_CENTER) begin
      psum_q <= '0;
      wsum_q <= '0;
    end else if (s2_vld_q) begin
      psum_q <= psum_q + PSUM_W'(p2_q) * PSUM_W'(wt);
      wsum_q <= wsum_q + WSUM_W'(wt);
    end
  end

  // divider
  bgf_div_ctl_t div_in, div_out;
  logic [7:0]   quot;

  assign div_in.start = (state_q == ST_FLUSH) && !s1_vld_q && !s2_vld_q;
  assign div_in.done  = 1'b0;

  bgf_divider #(
    .NUM_W (PSUM_W),
    .DEN_W (WSUM_W),
    .Q_W   (8)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_in),
    .ctl_o  (div_out),
    .num_i  (psum_q),
    .den_i  (wsum_q),
    .quot_o (quot)
  );

  // sequencer
  logic out_load;
  assign out_load = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_CENTER;
      ST_CENTER: state_d = emit_q ? ST_TAPS : ST_IDLE;
      ST_TAPS:   if (last_dx && last_dy) state_d = ST_FLUSH;
      ST_FLUSH:  if (div_in.start) state_d = ST_DIV;
      ST_DIV:    if (div_out.done) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // output register
  logic       m_valid_q;
  logic [7:0] m_data_q;
  logic       m_last_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= quot;
      m_last_q <= out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      k_q        <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      emit_q     <= 1'b0;
      dy_q       <= '0;
      dx_q       <= '0;
      tap_slot_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        emit_q <= emit_now;
      end

      // advance the input position on each stored pixel
      if (store) begin
        k_q <= k_q + 1'b1;
        if (in_col_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
          in_slot_q <= (in_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end

      // start the window walk RADIUS rows above the output pixel
      if (state_q == ST_CENTER) begin
        dy_q <= '0;
        dx_q <= '0;
        tap_slot_q <= (start_slot >= (SLOT_W + 1)'(SLOTS)) ?
                      SLOT_W'(start_slot - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(start_slot);
      end else if (state_q == ST_TAPS) begin
        if (last_dx) begin
          dx_q <= '0;
          dy_q <= dy_q + 1'b1;
          tap_slot_q <= (tap_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : tap_slot_q + 1'b1;
        end else begin
          dx_q <= dx_q + 1'b1;
        end
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
        if (out_last) begin
          // frame complete: rewind every position for the next frame
          in_row_q   <= '0;
          in_col_q   <= '0;
          in_slot_q  <= '0;
          k_q        <= '0;
          out_row_q  <= '0;
          out_col_q  <= '0;
          out_slot_q <= '0;
        end else if (out_col_wrap) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_slot_q <= (out_slot_q == SLOT_W'(SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // register write aborts any frame in progress
      if (cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT)) begin
        if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
          width_q <= cfg_data_i[WIDTH_REG_W-1:0];
        end else begin
          height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        end
        in_row_q   <= '0;
        in_col_q   <= '0;
        in_slot_q  <= '0;
        k_q        <= '0;
        out_row_q  <= '0;
        out_col_q  <= '0;
        out_slot_q <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/bgf_checker.sv @@
// Port-level checks for the gray bilateral filter, bound to the top level.
// Depends on gray_bilateral_filter_unit.
module bgf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one request at a time: busy right after each accepted request
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // a result never appears in the cycle right after a request
  a_no_fast_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // no new result is loaded while the accepted request reads its centre pixel
  a_no_fast_out2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind gray_bilateral_filter_unit bgf_checker u_bgf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_top.sv @@
// Self-checking bench for gray_bilateral_filter_unit: directed rows, then random frames.
// Depends on bgf_pkg and the filter RTL; holds its own model of the filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bgf_pkg::*;

  localparam int RAD   = 2;
  localparam int SLOTS = 2 * RAD + 2;
  localparam int MAXW  = 1024;
  localparam int MAXH  = 4096;
  localparam int WB    = 16;
  localparam int SETTLE = 45;
  // index values with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] pixel
  logic [0:0]            s_axis_tuser = '0;   // [0] kind (1 = drain tick)
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] filtered
  logic [0:0]            m_axis_tuser;        // [0] frame_end

  gray_bilateral_filter_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filter model: line store, counters, registers and weight tables
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] filtered;
    logic       frame_end;
  } filt_px_t;

  logic [7:0]  pixel_lines [SLOTS][MAXW];
  int unsigned row_in, col_in, row_out, col_out;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  longint unsigned spatial_w [2*RAD*RAD+1];
  longint unsigned range_w [256];
  bit          frame_closed;   // set when the model emits frame_end

  filt_px_t pending_px [$];
  int       errors = 0;
  int       src_idle = 0, dst_stall = 0;
  int       hold_req = 0;

  // e^(-1/b) in Q1.31 from the alternating series
  function automatic longint unsigned gauss_base(longint unsigned b);
    longint unsigned t, pos, neg;
    t = 64'd1 << 31;
    pos = t;
    neg = 0;
    for (int k = 1; k < 64 && t != 0; k++) begin
      t = t / (b * k);
      if (k % 2) neg += t;
      else pos += t;
    end
    return pos - neg;
  endfunction

  function automatic longint unsigned gauss_weight(longint unsigned a, longint unsigned b);
    longint unsigned p, r, v;
    p = gauss_base(b);
    r = 64'd1 << 31;
    while (a != 0) begin
      if (a[0]) r = (r * p + (64'd1 << 30)) >> 31;
      p = (p * p + (64'd1 << 30)) >> 31;
      a >>= 1;
    end
    v = ((r << WB) + (64'd1 << 30)) >> 31;
    if (v > (64'd1 << WB) - 1) v = (64'd1 << WB) - 1;
    return v;
  endfunction

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > MAXW) ? MAXW : width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    return (height_reg > MAXH) ? MAXH : height_reg;
  endfunction

  function automatic void clear_pos();
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
  endfunction

  // Weighted mean of the window around the next output position.
  function automatic filt_px_t filter_next(int unsigned w, int unsigned h);
    longint unsigned psum, wsum, wt;
    int   y, x;
    logic [7:0] ctr, p, d;
    bit   last;
    filt_px_t res;
    psum = 0;
    wsum = 0;
    ctr = pixel_lines[row_out % SLOTS][col_out];
    for (int dy = -RAD; dy <= RAD; dy++) begin
      y = int'(row_out) + dy;
      if (y < 0 || y >= int'(h)) continue;
      for (int dx = -RAD; dx <= RAD; dx++) begin
        x = int'(col_out) + dx;
        if (x < 0 || x >= int'(w)) continue;
        p = pixel_lines[y % SLOTS][x];
        d = (p > ctr) ? p - ctr : ctr - p;
        wt = (spatial_w[dy*dy + dx*dx] * range_w[d]) >> WB;
        psum += p * wt;
        wsum += wt;
      end
    end
    res.filtered = (wsum != 0) ? 8'(psum / wsum) : 8'd0;
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    res.frame_end = last;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (last) begin
      clear_pos();
      frame_closed = 1'b1;
    end
    return res;
  endfunction

  // Advance the model by one accepted request; returns 1 when it yields a pixel.
  function automatic bit filter_step(logic kind, logic [7:0] pix, output filt_px_t res);
    int unsigned w, h;
    longint unsigned k;
    w = eff_w();
    h = eff_h();
    res = '0;
    if (row_in >= h) begin
      res = filter_next(w, h);
      return 1'b1;
    end
    if (kind == KIND_DRAIN) return 1'b0;
    pixel_lines[row_in % SLOTS][col_in] = pix;
    k = longint'(row_in) * w + col_in;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (k >= RAD * w + RAD) begin
      res = filter_next(w, h);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle: drain, then let in-flight work settle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val[10:0];
      clear_pos();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = val;
      clear_pos();
    end
  endtask

  // Offer one request; when chk is set the typed value replaces the model's.
  task automatic send_req(logic kind, logic [7:0] pix, bit chk = 0, filt_px_t typed = '0);
    filt_px_t res;
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    if (filter_step(kind, pix, res)) pending_px.push_back(chk ? typed : res);
  endtask

  // Send a frame's pixels with drain ticks sprinkled in; stop after n_pix pixels
  // when the frame is to be cut short, else drain until frame_end.
  task automatic run_frame(logic [10:0] wv, logic [12:0] hv, int n_pix, ref int count);
    write_reg(CFG_IMAGE_WIDTH, 13'(wv));
    write_reg(CFG_IMAGE_HEIGHT, hv);
    frame_closed = 1'b0;
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(9) == 0) send_req(KIND_DRAIN, 8'($urandom));
      send_req(KIND_PIXEL, 8'($urandom));
      count++;
    end
    if (n_pix >= eff_w() * eff_h()) begin
      while (!frame_closed) begin
        send_req(logic'($urandom_range(1)), 8'($urandom));
        count++;
      end
    end
  endtask

  task automatic set_idling(int src, int dst);
    src_idle = src;
    dst_stall = dst;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_stall);
    end
  end

  // Compare each result against the oldest expectation.
  always @(posedge clk_i) begin
    filt_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d frame_end=%0d",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (m_axis_tdata !== want.filtered) begin
          $display("%0t: filtered expected %0d actual %0d", $time, want.filtered, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.frame_end) begin
          $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
                   m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed table: config writes and requests; typed results where obvious
  // ---------------------------------------------------------------------
  typedef enum logic {ROW_CFG, ROW_REQ} row_op_e;
  typedef struct {
    row_op_e     op;
    logic [1:0]  sel;    // register index, or kind
    logic [12:0] val;    // register value, or pixel
    bit          chk;
    logic [7:0]  filt;
    logic        fend;
  } dir_row_t;

  localparam int N_DIR = 27;
  dir_row_t dir_rows [N_DIR] = '{
    // 1 x 1 frames: the output is the lone pixel itself
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd1, 0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd1, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd0,   0, 8'd0,   1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd0,   1, 8'd0,   1'b1},
    '{ROW_REQ, KIND_PIXEL, 13'd255, 0, 8'd0,   1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd255, 1, 8'd255, 1'b1},
    '{ROW_REQ, KIND_PIXEL, 13'd77,  0, 8'd0,   1'b0},
    // pixel past the frame's end acts as a drain tick
    '{ROW_REQ, KIND_PIXEL, 13'd200, 1, 8'd77,  1'b1},
    // writes to unmapped indexes change nothing
    '{ROW_CFG, CFG_SPARE_2, 13'd5,    0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_SPARE_3, 13'd8191, 0, 8'd0, 1'b0},
    // zero sizes clamp to one
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd0, 0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd0, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd128, 0, 8'd0,   1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd0,   1, 8'd128, 1'b1},
    // 3 x 2 frame with a drain tick mid-frame, then drained
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd3, 0, 8'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd2, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd0,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd255, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd9,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd0,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd255, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd0,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd255, 0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd0,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd0,   0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_PIXEL, 13'd31,  0, 8'd0, 1'b0},
    '{ROW_REQ, KIND_DRAIN, 13'd0,   0, 8'd0, 1'b0}
  };

  initial begin
    int count;
    int frame_no;
    filt_px_t typed;
    count = 0;
    frame_no = 0;
    for (int i = 0; i < $size(spatial_w); i++) spatial_w[i] = gauss_weight(i, 2 * RAD * RAD);
    for (int i = 0; i < 256; i++) range_w[i] = gauss_weight(i * i, 8 * RAD * RAD);
    for (int s = 0; s < SLOTS; s++)
      for (int c = 0; c < MAXW; c++) pixel_lines[s][c] = '0;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    clear_pos();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        write_reg(dir_rows[i].sel, dir_rows[i].val);
      end else begin
        typed.filtered = dir_rows[i].filt;
        typed.frame_end = dir_rows[i].fend;
        send_req(dir_rows[i].sel[0], dir_rows[i].val[7:0], dir_rows[i].chk, typed);
      end
    end
    // finish off the 3 x 2 frame
    frame_closed = 1'b0;
    while (!frame_closed) send_req(KIND_DRAIN, 8'd0);

    // register extremes: all-ones width clamps to full line, all-ones height; both cut short
    set_idling(0, 0);
    run_frame(11'd2047, 13'd1, 40, count);
    run_frame(11'd1, 13'd8191, 12, count);

    // long receiver hold-off so the block backs up onto its input
    hold_req = 400;
    run_frame(11'd8, 13'd6, 48, count);

    while (count < 1000) begin
      case (frame_no % 4)
        0: set_idling(0, 0);
        1: set_idling(67, 0);
        2: set_idling(0, 67);
        default: set_idling(26, 26);
      endcase
      if (frame_no % 7 == 3) wait_drained();
      if (frame_no % 9 == 5) begin
        // cut a frame short when it is bigger than the pixels sent, then restart
        run_frame(11'($urandom_range(1, 12)), 13'($urandom_range(2, 8)),
                  $urandom_range(1, 20), count);
      end else if (frame_no % 13 == 7) begin
        run_frame(11'($urandom_range(30, 64)), 13'($urandom_range(1, 3)), 0, count);
        run_frame(11'(eff_w()), 13'(eff_h()), eff_w() * eff_h(), count);
      end else begin
        run_frame(11'($urandom_range(1, 12)), 13'($urandom_range(1, 8)), 0, count);
        run_frame(11'(eff_w()), 13'(eff_h()), eff_w() * eff_h(), count);
      end
      frame_no++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bgf_pkg.sv
hw/rtl/bgf_line_mem.sv
hw/rtl/bgf_divider.sv
hw/rtl/gray_bilateral_filter_unit.sv
hw/rtl/bgf_checker.sv
tb/tb_top.sv
